FILE: hdl/mh3_pkg.sv
// ----------------------------------------------------------------------------
// mh3_pkg
// Shared constants and controller/datapath interface types for the
// MurmurHash3 x86_32 byte stream hasher.
// ----------------------------------------------------------------------------
package mh3_pkg;

  localparam logic [31:0] MH_C1      = 32'hcc9e2d51;
  localparam logic [31:0] MH_C2      = 32'h1b873593;
  localparam logic [31:0] MH_N       = 32'he6546b64;
  localparam logic [31:0] MH_F1      = 32'h85ebca6b;
  localparam logic [31:0] MH_F2      = 32'hc2b2ae35;
  localparam logic [31:0] MH_MASK    = 32'd24573;
  localparam logic [31:0] SEED_RESET = 32'd23;

  // datapath operations
  typedef enum logic [3:0] {
    DP_NOP,
    DP_ABSORB,   // take one byte into the partial word
    DP_K1,       // prod = word * C1
    DP_K2,       // prod = rotl15(prod) * C2
    DP_MIX,      // hash = rotl13(hash ^ prod) * 5 + N
    DP_TSEL,     // acc = open ? hash : seed
    DP_TXOR,     // acc ^= prod (tail)
    DP_AV1,      // prod = fmix step one
    DP_AV2,      // prod = fmix step two
    DP_EMIT      // load output register, clear key state
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic phase_last;    // three bytes pending: next byte completes a word
    logic tail_pending;  // one to three bytes pending
    logic out_free;      // output register can take a result this cycle
  } dp_status_t;

endpackage

FILE: hdl/mh3_ctrl.sv
// ----------------------------------------------------------------------------
// mh3_ctrl
// Sequencer: accepts input transactions and steps the datapath through
// word mixing, tail mixing and the final avalanche.
// ----------------------------------------------------------------------------
module mh3_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_byte_present,
  input  logic                in_key_end,
  input  mh3_pkg::dp_status_t st,
  output mh3_pkg::dp_cmd_t    cmd
);
  import mh3_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_K1   = 9'b000000010,
    S_K2   = 9'b000000100,
    S_MIX  = 9'b000001000,
    S_TSEL = 9'b000010000,
    S_TXOR = 9'b000100000,
    S_AV1  = 9'b001000000,
    S_AV2  = 9'b010000000,
    S_EMIT = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;
  logic   tail_r, tail_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    tail_nxt  = tail_r;
    cmd.op    = DP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.op   = DP_ABSORB;
          last_nxt = in_key_end;
          if (in_byte_present && st.phase_last) begin
            state_nxt = S_K1;
          end else if (in_key_end) begin
            state_nxt = S_TSEL;
          end
        end
      end
      S_K1: begin
        cmd.op    = DP_K1;
        state_nxt = S_K2;
      end
      S_K2: begin
        cmd.op    = DP_K2;
        state_nxt = tail_r ? S_TXOR : S_MIX;
      end
      S_MIX: begin
        cmd.op    = DP_MIX;
        state_nxt = last_r ? S_TSEL : S_IDLE;
      end
      S_TSEL: begin
        cmd.op    = DP_TSEL;
        tail_nxt  = 1'b1;
        state_nxt = st.tail_pending ? S_K1 : S_AV1;
      end
      S_TXOR: begin
        cmd.op    = DP_TXOR;
        state_nxt = S_AV1;
      end
      S_AV1: begin
        cmd.op    = DP_AV1;
        state_nxt = S_AV2;
      end
      S_AV2: begin
        cmd.op    = DP_AV2;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.op    = DP_EMIT;
          tail_nxt  = 1'b0;
          last_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= 1'b0;
      tail_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
      tail_r  <= tail_nxt;
    end
  end

endmodule

FILE: hdl/mh3_dpath.sv
// ----------------------------------------------------------------------------
// mh3_dpath
// Hash datapath: seed register, key state, one shared 32x32 multiplier with
// a registered product, and the output register.
// ----------------------------------------------------------------------------
module mh3_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  mh3_pkg::dp_cmd_t    cmd,
  output mh3_pkg::dp_status_t st,
  input  logic [7:0]          in_key_byte,
  input  logic                in_byte_present,
  input  logic                cfg_valid,
  input  logic [31:0]         cfg_hash_seed,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_hash_value
);
  import mh3_pkg::*;

  logic [31:0] seed_r, seed_nxt;
  logic [31:0] hash_r, hash_nxt;
  logic [31:0] word_r, word_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [31:0] count_r, count_nxt;
  logic        open_r, open_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        oval_r, oval_nxt;
  logic [31:0] ohash_r, ohash_nxt;

  logic [31:0] mul_a, mul_b, mul_lo;
  logic [31:0] mix_t, mix_rot;
  logic [31:0] av_x, av_x1, av_y;
  logic [31:0] byte_shifted;

  assign st.phase_last   = (phase_r == 2'd3);
  assign st.tail_pending = (phase_r != 2'd0);
  assign st.out_free     = !oval_r || out_ready;

  assign out_valid      = oval_r;
  assign out_hash_value = ohash_r;

  assign byte_shifted = {24'd0, in_key_byte} << {phase_r, 3'b000};
  assign mix_t        = hash_r ^ prod_r;
  assign mix_rot      = {mix_t[18:0], mix_t[31:19]};
  assign av_x         = acc_r ^ count_r;
  assign av_x1        = av_x ^ (av_x >> 16);
  assign av_y         = prod_r ^ (prod_r >> 13);

  // shared multiplier, low 32 bits only
  always_comb begin
    mul_a = word_r;
    mul_b = MH_C1;
    case (cmd.op)
      DP_K2: begin
        mul_a = {prod_r[16:0], prod_r[31:17]};
        mul_b = MH_C2;
      end
      DP_AV1: begin
        mul_a = av_x1;
        mul_b = MH_F1;
      end
      DP_AV2: begin
        mul_a = av_y;
        mul_b = MH_F2;
      end
      default: begin
        mul_a = word_r;
        mul_b = MH_C1;
      end
    endcase
  end
  assign mul_lo = mul_a * mul_b;

  always_comb begin
    seed_nxt  = cfg_valid ? cfg_hash_seed : seed_r;
    hash_nxt  = hash_r;
    word_nxt  = word_r;
    phase_nxt = phase_r;
    count_nxt = count_r;
    open_nxt  = open_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    ohash_nxt = ohash_r;
    oval_nxt  = out_ready ? 1'b0 : oval_r;
    unique case (cmd.op)
      DP_NOP: begin
      end
      DP_ABSORB: begin
        if (in_byte_present) begin
          if (!open_r) begin
            hash_nxt = seed_r;
          end
          open_nxt  = 1'b1;
          word_nxt  = word_r | byte_shifted;
          phase_nxt = phase_r + 2'd1;
          count_nxt = count_r + 32'd1;
        end
      end
      DP_K1, DP_K2, DP_AV1, DP_AV2: begin
        prod_nxt = mul_lo;
      end
      DP_MIX: begin
        // x*5 as x + 4x
        hash_nxt = mix_rot + {mix_rot[29:0], 2'b00} + MH_N;
        word_nxt = 32'd0;
      end
      DP_TSEL: begin
        acc_nxt = open_r ? hash_r : seed_r;
      end
      DP_TXOR: begin
        acc_nxt = acc_r ^ prod_r;
      end
      DP_EMIT: begin
        ohash_nxt = prod_r ^ (prod_r >> 16) ^ MH_MASK;
        oval_nxt  = 1'b1;
        hash_nxt  = 32'd0;
        word_nxt  = 32'd0;
        phase_nxt = 2'd0;
        count_nxt = 32'd0;
        open_nxt  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r  <= SEED_RESET;
      hash_r  <= 32'd0;
      word_r  <= 32'd0;
      phase_r <= 2'd0;
      count_r <= 32'd0;
      open_r  <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      seed_r  <= seed_nxt;
      hash_r  <= hash_nxt;
      word_r  <= word_nxt;
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      open_r  <= open_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    ohash_r <= ohash_nxt;
  end

endmodule

FILE: hdl/murmur3_byte_stream_hash.sv
// ----------------------------------------------------------------------------
// murmur3_byte_stream_hash
// MurmurHash3 x86_32 over a key streamed one byte per input transaction.
// ----------------------------------------------------------------------------
// Keys arrive one byte per input transaction; in_key_end marks the last
// transaction of a key, and in_byte_present = 0 on that transaction closes
// the key without adding a byte (an empty key if no byte came before). Each
// key yields one out_hash_value: the MurmurHash3 x86_32 of the key, seeded
// from cfg_hash_seed (23 after reset), XORed with 24573. A byte that does
// not complete a four-byte word is only accepted; a byte that completes a
// word is accepted, then goes through two multiplies and the hash update.
// Closing a key adds tail select, two avalanche multiplies and output load,
// and with one to three tail bytes pending also two more multiplies and the
// tail XOR, plus any wait of the output register on out_ready. in_ready is
// low until these steps are done. All multiplies go through one shared
// 32x32 multiplier with a registered product, so they run one at a time.
// The seed write is taken every cycle; a new seed applies from the next
// key on.
// ----------------------------------------------------------------------------
module murmur3_byte_stream_hash (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_key_byte,
  input  logic        in_byte_present,
  input  logic        in_key_end,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_hash_value,
  // seed register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_hash_seed
);
  import mh3_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  // the seed register takes a write in any cycle
  assign cfg_ready = 1'b1;

  // sequencer: owns the input handshake
  mh3_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte_present (in_byte_present),
    .in_key_end      (in_key_end),
    .st              (st),
    .cmd             (cmd)
  );

  // datapath: key state, multiplier, output register
  mh3_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_key_byte     (in_key_byte),
    .in_byte_present (in_byte_present),
    .cfg_valid       (cfg_valid),
    .cfg_hash_seed   (cfg_hash_seed),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hash_value  (out_hash_value)
  );

endmodule

FILE: hdl/mh3_checker.sv
// ----------------------------------------------------------------------------
// mh3_checker
// Port-level checks for murmur3_byte_stream_hash, bound to the top level.
// ----------------------------------------------------------------------------
module mh3_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_key_end,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_hash_value,
  input logic        cfg_ready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hash_value))
    else $error("result changed while stalled");

  // closing a key always takes the finishing sequence
  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_key_end |=> !in_ready)
    else $error("input taken right after key end");

  // a result is only produced out of the finishing sequence
  a_rose_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");

  // the seed register never back-pressures
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("seed write stalled");

endmodule

bind murmur3_byte_stream_hash mh3_checker u_mh3_checker (.*);

FILE: tb/sv/murmur3_byte_stream_hash_tb.sv
// ----------------------------------------------------------------------------
// murmur3_byte_stream_hash_tb
// Self-checking bench for the MurmurHash3 x86_32 byte stream hasher.
// ----------------------------------------------------------------------------
// Keys are streamed one byte per input transaction. A behavioral hash model
// runs alongside the block, updated on every accepted input transaction, and
// queues the hash each closing transaction should produce. Every accepted
// output transaction is checked against the oldest queued hash. Stimulus is a
// short directed set (empty keys, tail lengths, extreme bytes and seeds,
// a seed change inside a key) followed by random keys with random idling
// on both channels and a stretch at full rate.
// ----------------------------------------------------------------------------
module murmur3_byte_stream_hash_tb;
  import mh3_pkg::*;

  // idle cycles after the last result before the block counts as quiet
  localparam int QUIET_CYCLES = 16;
  localparam int SHOWN_ERRORS = 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_key_byte = 8'h00;
  logic        in_byte_present = 1'b0;
  logic        in_key_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_hash_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_hash_seed = 32'h0;

  // hash model state
  logic [31:0] seed_model = SEED_RESET;
  logic [31:0] run_hash = 32'h0;
  logic [31:0] part_word = 32'h0;
  logic [1:0]  part_bytes = 2'd0;
  logic [31:0] key_len = 32'h0;
  logic        key_started = 1'b0;

  // hashes still owed by the block, oldest first
  logic [31:0] owed_hashes[$];

  // random idling on each side; cleared for the full-rate stretch
  logic gaps_on = 1'b1;
  logic stall_on = 1'b1;

  int error_count = 0;
  int keys_closed = 0;
  int bytes_sent = 0;
  int idle_items = 0;
  int items_sent = 0;
  int hashes_checked = 0;
  int seed_writes = 0;

  logic [31:0] owed;

  murmur3_byte_stream_hash i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_key_byte     (in_key_byte),
    .in_byte_present (in_byte_present),
    .in_key_end      (in_key_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hash_value  (out_hash_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_hash_seed   (cfg_hash_seed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Hash model
  // --------------------------------------------------------------------------
  function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  // per-word scramble: * C1, rotl 15, * C2 (products keep the low 32 bits)
  function automatic logic [31:0] scramble_word(input logic [31:0] k);
    logic [31:0] t;
    t = k * MH_C1;
    t = rotl32(t, 15);
    t = t * MH_C2;
    return t;
  endfunction

  function automatic logic [31:0] fmix32(input logic [31:0] h);
    logic [31:0] t;
    t = h ^ (h >> 16);
    t = t * MH_F1;
    t = t ^ (t >> 13);
    t = t * MH_F2;
    t = t ^ (t >> 16);
    return t;
  endfunction

  // Advance the model by one input transaction; has_hash says whether the
  // transaction closed a key, and hash holds the value the block owes then.
  task automatic hash_step(input logic [7:0] kb, input logic present,
                           input logic closing, output logic has_hash,
                           output logic [31:0] hash);
    logic [31:0] h;
    has_hash = 1'b0;
    hash = 32'h0;
    if (present) begin
      // first byte of a key latches the seed; a later seed write waits
      if (!key_started) begin
        run_hash = seed_model;
        key_started = 1'b1;
      end
      part_word = part_word | ({24'h0, kb} << (8 * part_bytes));
      part_bytes = part_bytes + 2'd1;
      key_len = key_len + 32'd1;
      if (part_bytes == 2'd0) begin
        run_hash = rotl32(run_hash ^ scramble_word(part_word), 13);
        run_hash = run_hash * 32'd5 + MH_N;
        part_word = 32'h0;
      end
    end
    if (closing) begin
      // a close with no byte seen hashes the empty key from the live seed
      h = key_started ? run_hash : seed_model;
      if (part_bytes != 2'd0) h = h ^ scramble_word(part_word);
      h = fmix32(h ^ key_len) ^ MH_MASK;
      has_hash = 1'b1;
      hash = h;
      run_hash = 32'h0;
      part_word = 32'h0;
      part_bytes = 2'd0;
      key_len = 32'h0;
      key_started = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic note_error(input string what, input logic [31:0] want,
                            input logic [31:0] got);
    error_count++;
    if (error_count <= SHOWN_ERRORS)
      $display("mismatch %0d: %s expected %08h got %08h", error_count, what, want,
               got);
  endtask

  // output transactions are checked at the edge that takes them
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (owed_hashes.size() == 0) begin
        note_error("hash with none owed:", 32'h0, out_hash_value);
      end else begin
        owed = owed_hashes.pop_front();
        hashes_checked++;
        if (out_hash_value !== owed) note_error("hash_value", owed, out_hash_value);
      end
    end
  end

  // receiver backpressure, changed only on the falling edge
  always @(negedge clk) begin
    if (stall_on) out_ready <= ($urandom_range(99) >= 37);
    else out_ready <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------
  // One input transaction. Valid stays high after acceptance until the next
  // falling edge; every caller starts there, so it is never taken twice.
  task automatic send_item(input logic [7:0] kb, input logic present,
                           input logic closing);
    logic has_hash;
    logic [31:0] hash;
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_key_byte <= kb;
    in_byte_present <= present;
    in_key_end <= closing;
    do @(posedge clk); while (!in_ready);
    hash_step(kb, present, closing, has_hash, hash);
    if (has_hash) begin
      owed_hashes = {owed_hashes, hash};
      keys_closed++;
    end
    if (present) bytes_sent++;
    else if (!closing) idle_items++;
    if (present || closing) items_sent++;
  endtask

  // Hold the input off until every owed hash is back, then let any byte
  // still in the word pipeline settle.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed_hashes.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // only called once the block is quiet
  task automatic write_seed(input logic [31:0] seed);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_hash_seed <= seed;
    do @(posedge clk); while (!cfg_ready);
    seed_model = seed;
    seed_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return 8'h00;
    if (roll < 20) return 8'hff;
    return 8'($urandom_range(255));
  endfunction

  // One well-formed key of random length; some are closed by a bare
  // closing transaction, and a few idle transactions are mixed in as noise.
  task automatic send_random_key();
    int len;
    int roll;
    logic bare_close;
    roll = $urandom_range(99);
    if (roll < 8) len = 0;
    else if (roll < 68) len = $urandom_range(8, 1);
    else if (roll < 95) len = $urandom_range(24, 9);
    else len = $urandom_range(80, 25);
    bare_close = (len == 0) || ($urandom_range(99) < 20);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 4) send_item(pick_byte(), 1'b0, 1'b0);
      send_item(pick_byte(), 1'b1, !bare_close && (i == len - 1));
    end
    if (bare_close) send_item(pick_byte(), 1'b0, 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset seed: empty key, tails of one and three bytes, a whole word, extreme bytes,
  // a bare close after a full word and an idle transaction.
  task automatic test_short_keys();
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h7f, 1'b1, 1'b1);
  endtask

  task automatic test_seed_extremes();
    drain_results();
    write_seed(32'h0000_0000);
    send_item(8'ha5, 1'b0, 1'b1);
    for (int i = 1; i <= 5; i++) send_item(8'(i), 1'b1, i == 5);
    drain_results();
    write_seed(32'hffff_ffff);
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'haa, 1'b1, 1'b0);
    send_item(8'h55, 1'b1, 1'b1);
  endtask

  // A seed write inside an open key must not touch that key; the empty
  // key right after must pick it up.
  task automatic test_seed_mid_key();
    send_item(8'h11, 1'b1, 1'b0);
    send_item(8'h22, 1'b1, 1'b0);
    drain_results();
    write_seed(32'h9e37_79b9);
    send_item(8'h33, 1'b1, 1'b0);
    send_item(8'h44, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
  endtask

  // Random keys, with a seed change (extremes among them) every batch.
  task automatic test_random_keys(input int target);
    int first;
    int batch_first;
    int pick;
    first = items_sent;
    batch_first = items_sent;
    while (items_sent - first < target) begin
      send_random_key();
      if (items_sent - batch_first >= 90) begin
        drain_results();
        pick = $urandom_range(5);
        case (pick)
          0: write_seed(32'h0000_0000);
          1: write_seed(32'hffff_ffff);
          2: write_seed(SEED_RESET);
          default: write_seed($urandom());
        endcase
        batch_first = items_sent;
      end
    end
  endtask

  // Back-to-back transactions on both channels.
  task automatic test_full_rate(input int target);
    int first;
    first = items_sent;
    gaps_on = 1'b0;
    stall_on = 1'b0;
    while (items_sent - first < target) send_random_key();
    drain_results();
    gaps_on = 1'b1;
    stall_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_short_keys();
    test_seed_extremes();
    test_seed_mid_key();
    test_random_keys(790);
    test_full_rate(120);
    drain_results();

    if (owed_hashes.size() != 0)
      note_error("hash never returned:", owed_hashes[0], 32'h0);
    $display("hashed %0d keys from %0d bytes (%0d idle transactions), %0d checked",
             keys_closed, bytes_sent, idle_items, hashes_checked);
    $display("seed writes: %0d, including zero, all-ones and one inside a key",
             seed_writes);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", error_count);
      $display("FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #4000000;
    $display("watchdog expired with %0d hashes owed", owed_hashes.size());
    $display("FAIL");
    $finish;
  end

endmodule
